// ===== src/frcc_pkg.sv =====
// Shared types and constants for the framed command relay controller.
// Frame markers, command codes, register indexes, port widths and the decode bundle.
// No dependencies.
package frcc_pkg;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int TIMER_W     = 25;

   localparam logic [7:0] FRAME_HEADER = 8'hAA;
   localparam logic [7:0] FRAME_FOOTER = 8'h55;

   localparam logic [15:0] TICKS_PER_MINUTE_RESET = 16'd60000;
   localparam logic [7:0]  SETUP_EXTRA_RESET      = 8'd10;

   typedef enum logic [7:0] {
      CMD_UNLOCK     = 8'h01,
      CMD_LOCK       = 8'h02,
      CMD_PROJ_POWER = 8'h03,
      CMD_PROJ_ALT   = 8'h04,
      CMD_LIGHTS_ON  = 8'h05,
      CMD_LIGHTS_OFF = 8'h06,
      CMD_AIR_ON     = 8'h07,
      CMD_AIR_OFF    = 8'h08,
      CMD_SETUP      = 8'h10,
      CMD_SHUTDOWN   = 8'h11
   } cmd_code_type;

   typedef enum logic {
      CSR_TICKS_PER_MINUTE = 1'b0,
      CSR_SETUP_EXTRA      = 1'b1
   } csr_index_type;

   // Control bundle from frame decode to the relay state.
   typedef struct packed {
      logic frame_ok;
      logic door_set;
      logic door_clr;
      logic lights_set;
      logic lights_clr;
      logic air_set;
      logic air_clr;
      logic pulse;
      logic arm;
      logic add_extra;
      logic disarm;
      logic shutdown;
   } cmd_ctrl_type;

endpackage

// ===== src/frcc_frame_decode.sv =====
// Frame check and command decode for the framed command relay controller.
// Depends on frcc_pkg.
module frcc_frame_decode
   import frcc_pkg::*;
(
   input  logic [7:0]   header_byte,
   input  logic [7:0]   command_code,
   input  logic [7:0]   duration_minutes,
   input  logic [7:0]   check_byte,
   input  logic [7:0]   footer_byte,
   output cmd_ctrl_type ctrl
);

   logic frame_good;
   logic dur_nonzero;

   assign frame_good  = (header_byte == FRAME_HEADER) && (footer_byte == FRAME_FOOTER) &&
                        (check_byte == (header_byte ^ command_code ^ duration_minutes));
   assign dur_nonzero = (duration_minutes != 8'd0);

   always_comb begin
      cmd_ctrl_type c;
      c = '0;
      c.frame_ok = 1'b1;
      case (cmd_code_type'(command_code))
         CMD_UNLOCK: begin
            c.door_set = 1'b1;
            c.arm      = dur_nonzero;
         end
         CMD_LOCK: begin
            c.door_clr = 1'b1;
            c.disarm   = 1'b1;
         end
         CMD_PROJ_POWER, CMD_PROJ_ALT: c.pulse = 1'b1;
         CMD_LIGHTS_ON:  c.lights_set = 1'b1;
         CMD_LIGHTS_OFF: c.lights_clr = 1'b1;
         CMD_AIR_ON:     c.air_set = 1'b1;
         CMD_AIR_OFF:    c.air_clr = 1'b1;
         CMD_SETUP: begin
            c.door_set   = 1'b1;
            c.lights_set = 1'b1;
            c.air_set    = 1'b1;
            c.pulse      = 1'b1;
            c.arm        = dur_nonzero;
            c.add_extra  = 1'b1;
         end
         CMD_SHUTDOWN: begin
            c.shutdown = 1'b1;
            c.pulse    = 1'b1;
         end
         default: c.frame_ok = 1'b0;
      endcase
      // drop every action of a bad frame
      if (!frame_good || !c.frame_ok) begin
         c = '0;
      end
      ctrl = c;
   end

endmodule

// ===== src/frcc_relay_state.sv =====
// Relay state, auto-lock timer and configuration registers.
// Computes the result of one item and commits the new state on advance.
// Depends on frcc_pkg.
module frcc_relay_state
   import frcc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   item_kind,
   input  logic                   link_connected,
   input  logic [7:0]             duration_minutes,
   input  cmd_ctrl_type           ctrl,
   input  logic                   csr_write,
   input  logic                   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic [RSP_TDATA_W-1:0] result
);

   logic               door_ff, door_in;
   logic               lights_ff, lights_in;
   logic               air_ff, air_in;
   logic               armed_ff, armed_in;
   logic [TIMER_W-1:0] ticks_ff, ticks_in;
   logic [15:0]        tpm_ff, tpm_in;
   logic [7:0]         extra_ff, extra_in;

   logic [8:0]         arm_minutes;
   logic [TIMER_W-1:0] arm_ticks;
   logic               pulse;
   logic               fired;
   logic               rsp_valid;
   logic               rsp_status;

   assign arm_minutes = ctrl.add_extra ? ({1'b0, duration_minutes} + {1'b0, extra_ff})
                                       : {1'b0, duration_minutes};
   assign arm_ticks   = {{(TIMER_W-9){1'b0}}, arm_minutes} * {{(TIMER_W-16){1'b0}}, tpm_ff};

   always_comb begin
      door_in    = door_ff;
      lights_in  = lights_ff;
      air_in     = air_ff;
      armed_in   = armed_ff;
      ticks_in   = ticks_ff;
      pulse      = 1'b0;
      fired      = 1'b0;
      rsp_valid  = 1'b0;
      rsp_status = 1'b0;
      if (item_kind) begin
         if (armed_ff) begin
            if (ticks_ff == '0) begin
               door_in   = 1'b0;
               lights_in = 1'b0;
               air_in    = 1'b0;
               armed_in  = 1'b0;
               pulse     = 1'b1;
               fired     = 1'b1;
            end else begin
               ticks_in = ticks_ff - 1'b1;
            end
         end
      end else begin
         if (ctrl.door_set)   door_in   = 1'b1;
         if (ctrl.door_clr)   door_in   = 1'b0;
         if (ctrl.lights_set) lights_in = 1'b1;
         if (ctrl.lights_clr) lights_in = 1'b0;
         if (ctrl.air_set)    air_in    = 1'b1;
         if (ctrl.air_clr)    air_in    = 1'b0;
         if (ctrl.disarm)     armed_in  = 1'b0;
         if (ctrl.arm) begin
            armed_in = 1'b1;
            ticks_in = arm_ticks;
         end
         if (ctrl.shutdown) begin
            door_in   = 1'b0;
            lights_in = 1'b0;
            air_in    = 1'b0;
            armed_in  = 1'b0;
            ticks_in  = '0;
         end
         pulse      = ctrl.pulse;
         rsp_valid  = link_connected;
         rsp_status = link_connected & ctrl.frame_ok;
      end
   end

   always_comb begin
      tpm_in   = tpm_ff;
      extra_in = extra_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_TICKS_PER_MINUTE: tpm_in = csr_data;
            CSR_SETUP_EXTRA:      extra_in = csr_data[7:0];
            default: begin
               tpm_in   = tpm_ff;
               extra_in = extra_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         door_ff   <= 1'b0;
         lights_ff <= 1'b0;
         air_ff    <= 1'b0;
         armed_ff  <= 1'b0;
         ticks_ff  <= '0;
         tpm_ff    <= TICKS_PER_MINUTE_RESET;
         extra_ff  <= SETUP_EXTRA_RESET;
      end else begin
         if (advance) begin
            door_ff   <= door_in;
            lights_ff <= lights_in;
            air_ff    <= air_in;
            armed_ff  <= armed_in;
            ticks_ff  <= ticks_in;
         end
         tpm_ff   <= tpm_in;
         extra_ff <= extra_in;
      end
   end

   assign result = {1'b0, fired, rsp_status, rsp_valid, pulse, air_in, lights_in, door_in};

endmodule

// ===== src/framed_command_relay_controller_top.sv =====
// Top level of the framed command relay controller: input register, result register
// and stream handshakes. Depends on frcc_pkg, frcc_frame_decode, frcc_relay_state.
//
// The block takes one item (a five-byte command frame or a timer tick) per clock cycle
// unless stalled, and returns exactly one result per item, in order. An input register
// feeds the frame check, command decode and relay/timer update, which write a result
// register; the input side keeps accepting while a finished result waits, and stalls
// only when both registers are full. The auto-lock timer counts ticks; an unlock or
// setup with a nonzero duration loads it with minutes (plus setup_extra for a setup)
// times ticks_per_minute (25 bits). Write configuration only while idle.
module framed_command_relay_controller_top
   import frcc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata, lowest bit up: header_byte[7:0], command_code[15:8],
   // duration_minutes[23:16], check_byte[31:24], footer_byte[39:32],
   // link_connected[40], zero fill [47:41]
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,   // kind: 0 frame, 1 tick
   // rsp_tdata, lowest bit up: door_unlocked, lights_on, aircon_on, projector_pulse,
   // response_valid, response_status, auto_lock_fired, zero fill [7]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic                   in_valid_ff, in_valid_in;
   logic                   in_kind_ff, in_kind_in;
   logic [40:0]            in_data_ff, in_data_in;
   logic                   out_valid_ff, out_valid_in;
   logic [RSP_TDATA_W-1:0] out_data_ff, out_data_in;

   logic                   advance;
   logic                   req_take;
   cmd_ctrl_type           ctrl;
   logic [RSP_TDATA_W-1:0] result;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   frcc_frame_decode u_decode (
      .header_byte      (in_data_ff[7:0]),
      .command_code     (in_data_ff[15:8]),
      .duration_minutes (in_data_ff[23:16]),
      .check_byte       (in_data_ff[31:24]),
      .footer_byte      (in_data_ff[39:32]),
      .ctrl             (ctrl)
   );

   frcc_relay_state u_state (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .item_kind        (in_kind_ff),
      .link_connected   (in_data_ff[40]),
      .duration_minutes (in_data_ff[23:16]),
      .ctrl             (ctrl),
      .csr_write        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .result           (result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_kind_in   = in_kind_ff;
      in_data_in   = in_data_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_kind_in  = req_tuser;
         in_data_in  = req_tdata[40:0];
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      // hold the result until its transfer completes
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = result;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_kind_ff  <= in_kind_in;
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
